// ----- hdl/stl_pkg.sv -----
// Shared types, character codes and helper functions for the script token lexer.
// No dependencies; used by every module under hdl.
`default_nettype none

package stl_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_TAG     = 3'd1,
        MODE_ECHO    = 3'd2,
        MODE_VAR     = 3'd3,
        MODE_NUM     = 3'd4,
        MODE_DISCARD = 3'd5
    } mode_t;

    typedef enum logic [3:0] {
        KIND_EOF        = 4'd0,
        KIND_OPEN_TAG   = 4'd1,
        KIND_ECHO       = 4'd2,
        KIND_VARIABLE   = 4'd3,
        KIND_NUMBER     = 4'd4,
        KIND_EQUAL      = 4'd5,
        KIND_PLUS       = 4'd6,
        KIND_SEMICOLON  = 4'd7,
        KIND_UNEXPECTED = 4'd8,
        KIND_TOO_LONG   = 4'd9
    } kind_t;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_LOW_P  = 8'h70;
    localparam logic [7:0] CH_LOW_H  = 8'h68;
    localparam logic [7:0] CH_LOW_E  = 8'h65;
    localparam logic [7:0] CH_LOW_C  = 8'h63;
    localparam logic [7:0] CH_LOW_O  = 8'h6F;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam logic [2:0] TAG_LEN  = 3'd5;
    localparam logic [2:0] ECHO_LEN = 3'd4;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        kind_t       kind;
        logic [31:0] start;
        logic [6:0]  length;
        logic [7:0]  offending;
    } result_t;

    typedef struct packed {
        result_t first;
        result_t second;
        logic    two;
    } packet_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

    function automatic logic [7:0] kw_char(input mode_t m, input logic [2:0] k);
        logic [7:0] c;
        c = CH_NUL;
        if (m == MODE_TAG) begin
            unique case (k)
                3'd0:    c = CH_LT;
                3'd1:    c = CH_QUEST;
                3'd2:    c = CH_LOW_P;
                3'd3:    c = CH_LOW_H;
                3'd4:    c = CH_LOW_P;
                default: c = CH_NUL;
            endcase
        end else begin
            unique case (k)
                3'd0:    c = CH_LOW_E;
                3'd1:    c = CH_LOW_C;
                3'd2:    c = CH_LOW_H;
                3'd3:    c = CH_LOW_O;
                default: c = CH_NUL;
            endcase
        end
        return c;
    endfunction

    function automatic logic [6:0] sat_len(input logic [7:0] len);
        return (len > 8'd127) ? 7'd127 : len[6:0];
    endfunction

    function automatic result_t make_res(input kind_t k, input logic [31:0] start,
                                         input logic [6:0] len, input logic [7:0] off);
        result_t r;
        r.kind      = k;
        r.start     = start;
        r.length    = len;
        r.offending = off;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/stl_front.sv -----
// Front end of the lexer: takes one source byte a beat, tracks the token in progress
// and pushes the one or two results a byte causes as one packet. Depends on stl_pkg.
`default_nettype none

module stl_front #(
    parameter int MAX_TOKEN_LEN  = 64,
    parameter int POSITION_WIDTH = 32
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [7:0]       s_source_byte,
    input  wire stl_pkg::q_stat_t q_stat,
    output logic                  push,
    output stl_pkg::packet_t      push_data
);

    localparam int LW = $clog2(MAX_TOKEN_LEN + 1);
    localparam logic [LW-1:0] MAX_LEN = LW'(MAX_TOKEN_LEN);
    localparam logic [6:0] MAX_LEN_SAT = (MAX_TOKEN_LEN > 127) ? 7'd127 : 7'(MAX_TOKEN_LEN);

    stl_pkg::mode_t            mode_reg, mode_next;
    logic [2:0]                kidx_reg, kidx_next;
    logic [POSITION_WIDTH-1:0] pos_reg, pos_next;
    logic [POSITION_WIDTH-1:0] start_reg, start_next;
    logic [LW-1:0]             len_reg, len_next;

    logic        take;
    logic [7:0]  b;
    logic [63:0] pos_wide, start_wide;
    logic [31:0] p32, start32;
    logic [6:0]  cur_len7;

    logic             idle_emit, idle_begin, idle_eof;
    stl_pkg::mode_t   idle_mode;
    stl_pkg::result_t idle_res;

    logic [7:0] kw_c;
    logic [2:0] kw_len;
    logic       kw_match, kw_done;
    logic       run_cont, run_full;
    stl_pkg::kind_t kw_kind, run_kind;

    logic             v0, v1, rearm;
    stl_pkg::result_t r0, r1;

    assign s_ready    = !q_stat.full;
    assign take       = s_valid && s_ready;
    assign b          = s_source_byte;
    assign pos_wide   = 64'(pos_reg);
    assign start_wide = 64'(start_reg);
    assign p32        = pos_wide[31:0];
    assign start32    = start_wide[31:0];
    assign cur_len7   = stl_pkg::sat_len(8'(len_reg));

    always_comb begin
        idle_emit  = 1'b0;
        idle_begin = 1'b0;
        idle_eof   = 1'b0;
        idle_mode  = stl_pkg::MODE_IDLE;
        idle_res   = stl_pkg::make_res(stl_pkg::KIND_EOF, p32, 7'd0, stl_pkg::CH_NUL);
        priority if (b == stl_pkg::CH_NUL) begin
            idle_emit = 1'b1;
            idle_eof  = 1'b1;
        end else if (stl_pkg::is_space(b)) begin
            idle_mode = stl_pkg::MODE_IDLE;
        end else if (b == stl_pkg::CH_LT) begin
            idle_begin = 1'b1;
            idle_mode  = stl_pkg::MODE_TAG;
        end else if (b == stl_pkg::CH_LOW_E) begin
            idle_begin = 1'b1;
            idle_mode  = stl_pkg::MODE_ECHO;
        end else if (b == stl_pkg::CH_DOLLAR) begin
            idle_begin = 1'b1;
            idle_mode  = stl_pkg::MODE_VAR;
        end else if (stl_pkg::is_digit(b)) begin
            idle_begin = 1'b1;
            idle_mode  = stl_pkg::MODE_NUM;
        end else if (b == stl_pkg::CH_EQUAL) begin
            idle_emit = 1'b1;
            idle_res  = stl_pkg::make_res(stl_pkg::KIND_EQUAL, p32, 7'd1, stl_pkg::CH_NUL);
        end else if (b == stl_pkg::CH_PLUS) begin
            idle_emit = 1'b1;
            idle_res  = stl_pkg::make_res(stl_pkg::KIND_PLUS, p32, 7'd1, stl_pkg::CH_NUL);
        end else if (b == stl_pkg::CH_SEMI) begin
            idle_emit = 1'b1;
            idle_res  = stl_pkg::make_res(stl_pkg::KIND_SEMICOLON, p32, 7'd1,
                                          stl_pkg::CH_NUL);
        end else begin
            idle_emit = 1'b1;
            idle_mode = stl_pkg::MODE_DISCARD;
            idle_res  = stl_pkg::make_res(stl_pkg::KIND_UNEXPECTED, p32, 7'd1, b);
        end
    end

    always_comb begin
        kw_c     = stl_pkg::kw_char(mode_reg, kidx_reg);
        kw_len   = (mode_reg == stl_pkg::MODE_TAG) ? stl_pkg::TAG_LEN : stl_pkg::ECHO_LEN;
        kw_kind  = (mode_reg == stl_pkg::MODE_TAG) ? stl_pkg::KIND_OPEN_TAG
                                                   : stl_pkg::KIND_ECHO;
        kw_match = (kidx_reg < kw_len) && (b == kw_c);
        kw_done  = (kidx_reg + 3'd1) == kw_len;
        run_kind = (mode_reg == stl_pkg::MODE_VAR) ? stl_pkg::KIND_VARIABLE
                                                   : stl_pkg::KIND_NUMBER;
        run_cont = (mode_reg == stl_pkg::MODE_VAR)
                 ? (stl_pkg::is_letter(b) || stl_pkg::is_digit(b) || b == stl_pkg::CH_UNDER)
                 : stl_pkg::is_digit(b);
        run_full = len_reg >= MAX_LEN;
    end

    // next mode
    always_comb begin
        mode_next = mode_reg;
        unique case (mode_reg)
            stl_pkg::MODE_TAG, stl_pkg::MODE_ECHO: begin
                if (kw_match) begin
                    if (kw_done) mode_next = stl_pkg::MODE_IDLE;
                end else if (b == stl_pkg::CH_NUL) begin
                    mode_next = stl_pkg::MODE_IDLE;
                end else begin
                    mode_next = stl_pkg::MODE_DISCARD;
                end
            end
            stl_pkg::MODE_VAR, stl_pkg::MODE_NUM: begin
                if (run_cont) begin
                    if (run_full) mode_next = stl_pkg::MODE_DISCARD;
                end else begin
                    mode_next = idle_mode;
                end
            end
            stl_pkg::MODE_DISCARD: begin
                if (b == stl_pkg::CH_NUL) mode_next = stl_pkg::MODE_IDLE;
            end
            default: mode_next = idle_mode;
        endcase
    end

    // results and token registers
    always_comb begin
        v0         = 1'b0;
        v1         = 1'b0;
        rearm      = 1'b0;
        r0         = idle_res;
        r1         = idle_res;
        kidx_next  = kidx_reg;
        start_next = start_reg;
        len_next   = len_reg;
        unique case (mode_reg)
            stl_pkg::MODE_TAG, stl_pkg::MODE_ECHO: begin
                if (kw_match) begin
                    kidx_next = kidx_reg + 3'd1;
                    len_next  = len_reg + LW'(1);
                    if (kw_done) begin
                        kidx_next = 3'd0;
                        v0        = 1'b1;
                        r0        = stl_pkg::make_res(kw_kind, start32, 7'(kw_len),
                                                      stl_pkg::CH_NUL);
                    end
                end else begin
                    kidx_next = 3'd0;
                    v0        = 1'b1;
                    r0        = stl_pkg::make_res(stl_pkg::KIND_UNEXPECTED, start32, cur_len7,
                                                  stl_pkg::kw_char(mode_reg, 3'd0));
                    if (b == stl_pkg::CH_NUL) begin
                        v1    = 1'b1;
                        r1    = stl_pkg::make_res(stl_pkg::KIND_EOF, p32, 7'd0,
                                                  stl_pkg::CH_NUL);
                        rearm = 1'b1;
                    end
                end
            end
            stl_pkg::MODE_VAR, stl_pkg::MODE_NUM: begin
                if (run_cont) begin
                    if (run_full) begin
                        v0 = 1'b1;
                        r0 = stl_pkg::make_res(stl_pkg::KIND_TOO_LONG, start32, MAX_LEN_SAT,
                                               stl_pkg::CH_NUL);
                    end else begin
                        len_next = len_reg + LW'(1);
                    end
                end else begin
                    v0 = 1'b1;
                    r0 = stl_pkg::make_res(run_kind, start32, cur_len7, stl_pkg::CH_NUL);
                    v1 = idle_emit;
                    r1 = idle_res;
                    rearm = idle_eof;
                    if (idle_eof) kidx_next = 3'd0;
                    if (idle_begin) begin
                        kidx_next  = 3'd1;
                        start_next = pos_reg;
                        len_next   = LW'(1);
                    end
                end
            end
            stl_pkg::MODE_DISCARD: begin
                if (b == stl_pkg::CH_NUL) begin
                    v0        = 1'b1;
                    r0        = stl_pkg::make_res(stl_pkg::KIND_EOF, p32, 7'd0,
                                                  stl_pkg::CH_NUL);
                    rearm     = 1'b1;
                    kidx_next = 3'd0;
                end
            end
            default: begin
                v0    = idle_emit;
                r0    = idle_res;
                rearm = idle_eof;
                if (idle_eof) kidx_next = 3'd0;
                if (idle_begin) begin
                    kidx_next  = 3'd1;
                    start_next = pos_reg;
                    len_next   = LW'(1);
                end
            end
        endcase
        pos_next = rearm ? '0 : pos_reg + POSITION_WIDTH'(1);
    end

    assign push             = take && v0;
    assign push_data.first  = r0;
    assign push_data.second = r1;
    assign push_data.two    = v1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= stl_pkg::MODE_IDLE;
            kidx_reg  <= 3'd0;
            pos_reg   <= '0;
            start_reg <= '0;
            len_reg   <= '0;
        end else if (take) begin
            mode_reg  <= mode_next;
            kidx_reg  <= kidx_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            len_reg   <= len_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/stl_queue.sv -----
// Short packet queue between the lexer front end and the result serialiser.
// Depends on stl_pkg for the packet and status types.
`default_nettype none

module stl_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire stl_pkg::packet_t push_data,
    input  wire logic             pop,
    output stl_pkg::packet_t      pop_data,
    output stl_pkg::q_stat_t      q_stat
);

    stl_pkg::packet_t                entries_reg [stl_pkg::QDEPTH];
    logic [stl_pkg::QPTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [stl_pkg::QCNT_W-1:0]      count_reg, count_next;

    assign q_stat.full  = count_reg == stl_pkg::QCNT_W'(stl_pkg::QDEPTH);
    assign q_stat.empty = count_reg == '0;
    assign pop_data     = entries_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + stl_pkg::QCNT_W'(1);
        if (pop && !push) count_next = count_reg - stl_pkg::QCNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (push) entries_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + stl_pkg::QPTR_W'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + stl_pkg::QPTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/stl_back.sv -----
// Result serialiser: unpacks queued packets into single result beats from an output
// register and marks the last result of each source byte. Depends on stl_pkg.
`default_nettype none

module stl_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire stl_pkg::q_stat_t q_stat,
    input  wire stl_pkg::packet_t pop_data,
    output logic                  pop,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [3:0]            m_token_kind,
    output logic [31:0]           m_token_start,
    output logic [6:0]            m_token_length,
    output logic [7:0]            m_offending_byte,
    output logic                  m_last_of_run
);

    stl_pkg::packet_t hold_reg;
    logic             valid_reg;
    logic             second_reg;
    logic             last;
    stl_pkg::result_t cur;

    assign last = second_reg || !hold_reg.two;
    assign cur  = second_reg ? hold_reg.second : hold_reg.first;
    assign pop  = !q_stat.empty && (!valid_reg || (m_ready && last));

    assign m_valid          = valid_reg;
    assign m_token_kind     = cur.kind;
    assign m_token_start    = cur.start;
    assign m_token_length   = cur.length;
    assign m_offending_byte = cur.offending;
    assign m_last_of_run    = last;

    always_ff @(posedge aclk) begin
        if (pop) hold_reg <= pop_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end else if (pop) begin
            valid_reg  <= 1'b1;
            second_reg <= 1'b0;
        end else if (valid_reg && m_ready) begin
            if (last) begin
                valid_reg  <= 1'b0;
                second_reg <= 1'b0;
            end else begin
                second_reg <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/script_token_lexer_unit.sv -----
// Top level of the script token lexer: front end, packet queue and result serialiser.
// Depends on stl_pkg, stl_front, stl_queue and stl_back.
//
//  channel  | ports                                            | carries
//  ---------+--------------------------------------------------+-----------------------
//  input    | s_valid s_ready s_source_byte                    | one source byte a beat
//  result   | m_valid m_ready m_token_kind m_token_start       | one token result a beat
//           | m_token_length m_offending_byte m_last_of_run    |
//
// A byte is taken every cycle while the four-packet queue has room; its results are written
// into the queue and then popped from it into the output register.
// A byte that ends a token and is itself a one-byte token, an error or the zero byte
// gives two results, which leave the result port one after the other; the queue absorbs
// short bursts of such bytes.
// Reset returns the lexer to idle at offset zero and empties the queue.
// A stalled result port fills the queue and then holds s_ready low.
`default_nettype none

module script_token_lexer_unit #(
    parameter int MAX_TOKEN_LEN  = 64,
    parameter int POSITION_WIDTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_source_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_token_kind,
    output logic [31:0]      m_token_start,
    output logic [6:0]       m_token_length,
    output logic [7:0]       m_offending_byte,
    output logic             m_last_of_run
);

    stl_pkg::q_stat_t q_stat;
    stl_pkg::packet_t push_data, pop_data;
    logic             push, pop;

    stl_front #(
        .MAX_TOKEN_LEN  (MAX_TOKEN_LEN),
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_source_byte (s_source_byte),
        .q_stat        (q_stat),
        .push          (push),
        .push_data     (push_data)
    );

    stl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    stl_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_stat           (q_stat),
        .pop_data         (pop_data),
        .pop              (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_token_kind     (m_token_kind),
        .m_token_start    (m_token_start),
        .m_token_length   (m_token_length),
        .m_offending_byte (m_offending_byte),
        .m_last_of_run    (m_last_of_run)
    );

    a_eof_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_token_kind == 4'(stl_pkg::KIND_EOF)
        |-> m_token_length == 7'd0 && m_last_of_run)
        else $error("eof result with nonzero length or not last of run");

    a_offending_only_unexpected: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_token_kind != 4'(stl_pkg::KIND_UNEXPECTED)
        |-> m_offending_byte == 8'd0)
        else $error("offending byte set on a result that is not unexpected");

    a_token_length_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_token_kind != 4'(stl_pkg::KIND_EOF)
        |-> m_token_length != 7'd0)
        else $error("token result with zero length");

    a_ready_drops_only_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(m_valid) && !($past(m_ready) && $past(m_last_of_run)))
        else $error("input stalled while the result port was draining");

endmodule

`default_nettype wire

// ----- verif/script_token_lexer_unit_test.sv -----
// Self-checking testbench for script_token_lexer_unit: drives source bytes, predicts
// every token result and checks each result beat against the prediction.
// Depends on stl_pkg and the script_token_lexer_unit RTL.
`default_nettype none

module script_token_lexer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import stl_pkg::*;

    localparam int TOKEN_LIMIT  = 64;
    localparam int ITEM_TARGET  = 900;
    localparam int CALM_ITEMS   = 150;
    localparam int TAIL_CYCLES  = 16;
    localparam int STALL_LIMIT  = 2000;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] start;
        logic [6:0]  length;
        logic [7:0]  offending;
        logic        last_of_run;
    } token_rec_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_source_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_token_kind;
    logic [31:0] m_token_start;
    logic [6:0]  m_token_length;
    logic [7:0]  m_offending_byte;
    logic        m_last_of_run;

    // lexer prediction state
    mode_t       lex_mode = MODE_IDLE;
    int          kw_idx = 0;
    logic [31:0] byte_pos = '0;
    logic [31:0] tok_start = '0;
    int          tok_len = 0;
    bit          rearm = 1'b0;

    token_rec_t  step_tokens[$];
    token_rec_t  tokens_due[$];

    bit          idle_on = 1'b1;
    bit          calm_source = 1'b0;
    int          stall_left = 0;
    int          bytes_sent = 0;
    int          results_checked = 0;
    int          mismatches = 0;
    int          quiet_cycles = 0;
    int          kinds_seen[0:9];

    script_token_lexer_unit #(
        .MAX_TOKEN_LEN  (TOKEN_LIMIT),
        .POSITION_WIDTH (32)
    ) u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_source_byte    (s_source_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_token_kind     (m_token_kind),
        .m_token_start    (m_token_start),
        .m_token_length   (m_token_length),
        .m_offending_byte (m_offending_byte),
        .m_last_of_run    (m_last_of_run)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic bit is_num(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic bit is_alpha(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    endfunction

    function automatic bit is_blank(input logic [7:0] b);
        return b == CH_SPACE || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic [7:0] keyword_char(input mode_t m, input int k);
        logic [7:0] tag_c, echo_c;
        tag_c  = (k == 0) ? CH_LT : (k == 1) ? CH_QUEST : (k == 3) ? CH_LOW_H : CH_LOW_P;
        echo_c = (k == 0) ? CH_LOW_E : (k == 1) ? CH_LOW_C : (k == 2) ? CH_LOW_H : CH_LOW_O;
        return (m == MODE_TAG) ? tag_c : echo_c;
    endfunction

    function automatic void lex_token(input kind_t k, input logic [31:0] s, input int len,
                                      input logic [7:0] off);
        token_rec_t r;
        r.kind        = k;
        r.start       = s;
        r.length      = (len > 127) ? 7'd127 : len[6:0];
        r.offending   = off;
        r.last_of_run = 1'b0;
        step_tokens.push_back(r);
    endfunction

    function automatic void lex_eof(input logic [31:0] p);
        lex_token(KIND_EOF, p, 0, CH_NUL);
        lex_mode = MODE_IDLE;
        kw_idx   = 0;
        rearm    = 1'b1;
    endfunction

    function automatic void open_token(input mode_t m, input logic [31:0] p);
        lex_mode  = m;
        kw_idx    = 1;
        tok_start = p;
        tok_len   = 1;
    endfunction

    function automatic void lex_idle(input logic [7:0] b, input logic [31:0] p);
        lex_mode = MODE_IDLE;
        if (b == CH_NUL) begin
            lex_eof(p);
        end else if (!is_blank(b)) begin
            if (b == CH_LT) begin
                open_token(MODE_TAG, p);
            end else if (b == CH_LOW_E) begin
                open_token(MODE_ECHO, p);
            end else if (b == CH_DOLLAR) begin
                open_token(MODE_VAR, p);
            end else if (is_num(b)) begin
                open_token(MODE_NUM, p);
            end else if (b == CH_EQUAL) begin
                lex_token(KIND_EQUAL, p, 1, CH_NUL);
            end else if (b == CH_PLUS) begin
                lex_token(KIND_PLUS, p, 1, CH_NUL);
            end else if (b == CH_SEMI) begin
                lex_token(KIND_SEMICOLON, p, 1, CH_NUL);
            end else begin
                lex_mode = MODE_DISCARD;
                lex_token(KIND_UNEXPECTED, p, 1, b);
            end
        end
    endfunction

    function automatic void lex_keyword(input logic [7:0] b, input logic [31:0] p,
                                        input int len, input kind_t k);
        if (kw_idx < len && b == keyword_char(lex_mode, kw_idx)) begin
            kw_idx++;
            tok_len++;
            if (kw_idx == len) begin
                lex_mode = MODE_IDLE;
                kw_idx   = 0;
                lex_token(k, tok_start, len, CH_NUL);
            end
        end else begin
            lex_token(KIND_UNEXPECTED, tok_start, tok_len, keyword_char(lex_mode, 0));
            lex_mode = MODE_DISCARD;
            kw_idx   = 0;
            if (b == CH_NUL) lex_eof(p);
        end
    endfunction

    function automatic void lex_run(input logic [7:0] b, input logic [31:0] p,
                                    input kind_t k, input bit more);
        if (more) begin
            if (tok_len >= TOKEN_LIMIT) begin
                lex_mode = MODE_DISCARD;
                lex_token(KIND_TOO_LONG, tok_start, TOKEN_LIMIT, CH_NUL);
            end else begin
                tok_len++;
            end
        end else begin
            lex_token(k, tok_start, tok_len, CH_NUL);
            lex_idle(b, p);
        end
    endfunction

    function automatic void predict_byte(input logic [7:0] b);
        logic [31:0] p;
        token_rec_t  r;
        p     = byte_pos;
        rearm = 1'b0;
        step_tokens.delete();
        case (lex_mode)
            MODE_TAG:     lex_keyword(b, p, 5, KIND_OPEN_TAG);
            MODE_ECHO:    lex_keyword(b, p, 4, KIND_ECHO);
            MODE_VAR:     lex_run(b, p, KIND_VARIABLE,
                                  is_alpha(b) || is_num(b) || b == CH_UNDER);
            MODE_NUM:     lex_run(b, p, KIND_NUMBER, is_num(b));
            MODE_DISCARD: if (b == CH_NUL) lex_eof(p);
            default:      lex_idle(b, p);
        endcase
        byte_pos = rearm ? 32'd0 : p + 32'd1;
        for (int i = 0; i < step_tokens.size(); i++) begin
            r = step_tokens[i];
            r.last_of_run = (i == step_tokens.size() - 1);
            tokens_due.push_back(r);
        end
    endfunction

    function automatic void report_mismatch(input string why, input token_rec_t want,
                                            input token_rec_t got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display({"[%0t] %0s: expected kind %0d start %0d len %0d off %02h last %0b,",
                      " got kind %0d start %0d len %0d off %02h last %0b"},
                     $realtime, why, want.kind, want.start, want.length, want.offending,
                     want.last_of_run, got.kind, got.start, got.length, got.offending,
                     got.last_of_run);
        end
    endfunction

    task automatic send_byte(input logic [7:0] b);
        if (idle_on && !calm_source && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_source_byte <= b;
        do @(posedge aclk); while (!s_ready);
        predict_byte(b);
        bytes_sent++;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) send_byte(txt[i]);
    endtask

    task automatic drain_results;
        s_valid <= 1'b0;
        do @(posedge aclk); while (tokens_due.size() != 0);
    endtask

    function automatic logic [7:0] ident_char;
        int r;
        r = $urandom_range(0, 62);
        if (r < 26) return 8'h61 + 8'(r);
        if (r < 52) return 8'h41 + 8'(r - 26);
        if (r < 62) return 8'h30 + 8'(r - 52);
        return CH_UNDER;
    endfunction

    function automatic logic [7:0] blank_char;
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CH_SPACE : 8'h09 + 8'(r);
    endfunction

    task automatic send_keyword(input mode_t m, input int len);
        int cut;
        cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, len - 1) : len;
        for (int i = 0; i < cut; i++) send_byte(keyword_char(m, i));
        if (cut < len) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_run(input bit as_variable);
        int len;
        len = ($urandom_range(0, 14) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 8);
        if (as_variable) begin
            send_byte(CH_DOLLAR);
            for (int i = 1; i < len; i++) send_byte(ident_char());
        end else begin
            for (int i = 0; i < len; i++) send_byte(8'h30 + 8'($urandom_range(0, 9)));
        end
    endtask

    task automatic test_directed_program;
        send_text("<?php\techo $_Z9=1+2;");
        send_byte(CH_NUL);
    endtask

    task automatic test_broken_keywords;
        send_text("<?x!");
        send_byte(CH_NUL);
        send_text("ech");
        send_byte(CH_NUL);
    endtask

    task automatic test_unexpected_bytes;
        send_byte(8'h0D);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(CH_NUL);
        send_byte(CH_NUL);
    endtask

    task automatic test_length_limit;
        send_byte(CH_DOLLAR);
        for (int i = 1; i < TOKEN_LIMIT; i++) send_byte(ident_char());
        send_byte(CH_SEMI);
        for (int i = 0; i < TOKEN_LIMIT; i++) send_byte(8'h30 + 8'($urandom_range(0, 9)));
        send_byte(CH_SPACE);
        for (int i = 0; i <= TOKEN_LIMIT; i++) send_byte(8'h39);
        send_byte(CH_PLUS);
        send_byte(CH_NUL);
    endtask

    task automatic test_drain_pause;
        send_text("$abc");
        drain_results();
        send_text(" 7");
        send_byte(CH_NUL);
        drain_results();
    endtask

    task automatic test_random_sources;
        int n_tok;
        int sel;
        while (bytes_sent < ITEM_TARGET) begin
            idle_on     = (bytes_sent < ITEM_TARGET - CALM_ITEMS);
            calm_source = ($urandom_range(0, 3) == 0);
            n_tok       = $urandom_range(0, 10);
            for (int t = 0; t < n_tok; t++) begin
                if ($urandom_range(0, 2) == 0) begin
                    repeat ($urandom_range(1, 3)) send_byte(blank_char());
                end
                sel = $urandom_range(0, 15);
                case (sel)
                    0, 1:          send_keyword(MODE_TAG, 5);
                    2, 3:          send_keyword(MODE_ECHO, 4);
                    4, 5, 6, 13:   send_run(1'b1);
                    7, 8, 9, 14:   send_run(1'b0);
                    10:            send_byte(CH_EQUAL);
                    11:            send_byte(CH_PLUS);
                    12:            send_byte(CH_SEMI);
                    default:       send_byte(8'($urandom_range(0, 255)));
                endcase
            end
            send_byte(CH_NUL);
        end
        calm_source = 1'b0;
    endtask

    initial begin
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                stall_left = $urandom_range(1, 9) - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : check_results
        token_rec_t got;
        token_rec_t want;
        if (aresetn && m_valid && m_ready) begin
            got.kind        = kind_t'(m_token_kind);
            got.start       = m_token_start;
            got.length      = m_token_length;
            got.offending   = m_offending_byte;
            got.last_of_run = m_last_of_run;
            if (m_token_kind < 4'd10) kinds_seen[m_token_kind]++;
            results_checked++;
            if (tokens_due.size() == 0) begin
                report_mismatch("result beat with nothing due", '0, got);
            end else begin
                want = tokens_due.pop_front();
                if (got.kind !== want.kind || got.start !== want.start ||
                    got.length !== want.length || got.offending !== want.offending ||
                    got.last_of_run !== want.last_of_run) begin
                    report_mismatch("result beat mismatch", want, got);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timed out with %0d results still due", tokens_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        foreach (kinds_seen[k]) kinds_seen[k] = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_program();
        test_broken_keywords();
        test_unexpected_bytes();
        test_length_limit();
        test_drain_pause();
        test_random_sources();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Lexed %0d source bytes over %0d sources, %0d token results checked",
                 bytes_sent, kinds_seen[KIND_EOF], results_checked);
        $display({"Seen: open tag %0d, echo %0d, variable %0d, number %0d,",
                  " unexpected %0d, too long %0d"},
                 kinds_seen[KIND_OPEN_TAG], kinds_seen[KIND_ECHO], kinds_seen[KIND_VARIABLE],
                 kinds_seen[KIND_NUMBER], kinds_seen[KIND_UNEXPECTED], kinds_seen[KIND_TOO_LONG]);
        if (mismatches == 0 && tokens_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
